>>> design/sbc_pkg.sv
package sbc_pkg;

    localparam int CW  = 32;        // coordinate width, signed Q16.16
    localparam int MW  = CW - 1;    // margin width, unsigned
    localparam int TF  = 30;        // fraction bits of a slab parameter
    localparam int XW  = CW + 5;    // doubled distances and sums
    localparam int TW  = TF + 3;    // signed slab parameter, saturated to +-2
    localparam int NL  = 6;         // near and far lane for each axis
    localparam int NST = TF + 1;    // quotient bits, one per divider stage
    localparam int PW  = CW + TF + 2;
    localparam int PAW = 5;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_MAX_X  = 3'd3;
    localparam logic [2:0] REG_MAX_Y  = 3'd4;
    localparam logic [2:0] REG_MAX_Z  = 3'd5;
    localparam logic [2:0] REG_MARGIN = 3'd6;

    typedef struct packed {
        logic signed [CW-1:0] seg_start_x;
        logic signed [CW-1:0] seg_start_y;
        logic signed [CW-1:0] seg_start_z;
        logic signed [CW-1:0] seg_end_x;
        logic signed [CW-1:0] seg_end_y;
        logic signed [CW-1:0] seg_end_z;
    } seg_in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_start_z;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
        logic signed [CW-1:0] clip_end_z;
    } seg_out_t;

    typedef struct packed {
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic [MW-1:0]      margin;
    } box_cfg_t;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] e;
        logic [2:0][CW:0]   dmag;
        logic [2:0]         dz;
        logic [2:0]         dneg;
        logic               zrej;
    } side_t;

    typedef struct packed {
        logic          neg;
        logic          sat;
        logic [XW-1:0] d;
        logic [XW-1:0] r;
        logic [TF:0]   q;
    } lane_t;

    typedef struct packed {
        lane_t [NL-1:0] lane;
        side_t          side;
    } div_word_t;

    typedef struct packed {
        logic        hit;
        logic [TF:0] tn;
        logic [TF:0] tfc;
        side_t       side;
    } sel_t;

    // saturation test and integer quotient bit
    function automatic lane_t div_first(lane_t x);
        lane_t y;
        y = x;
        y.sat = {1'b0, x.r} >= {x.d, 1'b0};
        y.q = '0;
        if (x.r >= x.d)
        begin
            y.r = x.r - x.d;
            y.q[0] = 1'b1;
        end
        return y;
    endfunction

    // one restoring step, one fraction bit
    function automatic lane_t div_next(lane_t x);
        lane_t       y;
        logic [XW:0] rs;
        y = x;
        rs = {x.r, 1'b0};
        y.q = {x.q[TF-1:0], 1'b0};
        if (rs >= {1'b0, x.d})
        begin
            rs = rs - {1'b0, x.d};
            y.q[0] = 1'b1;
        end
        y.r = rs[XW-1:0];
        return y;
    endfunction

    function automatic logic signed [TW-1:0] lane_t_value(lane_t x);
        logic [TW-1:0] m;
        m = x.sat ? (TW'(2) << TF) : TW'(x.q);
        return x.neg ? $signed(-m) : $signed(m);
    endfunction

endpackage

>>> design/segment_box_clipper_unit.sv
// slab-method clipper of 3d segments against an axis-aligned box, signed q16.16.
// one segment word is accepted per cycle and one clipped word leaves per cycle
// (hit = 0 and the endpoints unchanged when the segment misses the box); the
// pipeline is one setup stage, 31 stages of the restoring divider that
// forms six slab parameters at one quotient bit per stage, one selection stage,
// a multiply stage and the output register. stalls on the output hold every
// stage that is full; empty stages still fill. box corners and margin sit in
// apb registers at byte offsets 0x00..0x18 (min x,y,z, max x,y,z, margin) and
// must only be written while no segment is in flight.
module segment_box_clipper_unit (
    input  logic              clk,
    input  logic              rst_n,
    // segment words in
    input  logic              seg_valid,
    output logic              seg_ready,
    input  sbc_pkg::seg_in_t  seg,
    // clipped words out
    output logic              clip_valid,
    input  logic              clip_ready,
    output sbc_pkg::seg_out_t clip,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [sbc_pkg::PAW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import sbc_pkg::*;

    logic [2:0][CW-1:0] lo_reg;
    logic [2:0][CW-1:0] hi_reg;
    logic [MW-1:0]      margin_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;
    box_cfg_t           cfg;

    logic      slab_valid;
    logic      slab_ready;
    div_word_t slab_word;
    logic      div_valid;
    logic      div_ready;
    div_word_t div_word;
    logic      sel_valid;
    logic      sel_ready;
    sel_t      sel_word;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PAW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes, unknown offsets are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg     <= '0;
            hi_reg     <= '0;
            margin_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_X:  lo_reg[0]  <= pwdata[CW-1:0];
                REG_MIN_Y:  lo_reg[1]  <= pwdata[CW-1:0];
                REG_MIN_Z:  lo_reg[2]  <= pwdata[CW-1:0];
                REG_MAX_X:  hi_reg[0]  <= pwdata[CW-1:0];
                REG_MAX_Y:  hi_reg[1]  <= pwdata[CW-1:0];
                REG_MAX_Z:  hi_reg[2]  <= pwdata[CW-1:0];
                REG_MARGIN: margin_reg <= pwdata[MW-1:0];
                default:    ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_MIN_X:  prdata = lo_reg[0];
            REG_MIN_Y:  prdata = lo_reg[1];
            REG_MIN_Z:  prdata = lo_reg[2];
            REG_MAX_X:  prdata = hi_reg[0];
            REG_MAX_Y:  prdata = hi_reg[1];
            REG_MAX_Z:  prdata = hi_reg[2];
            REG_MARGIN: prdata = 32'(margin_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.lo     = lo_reg;
    assign cfg.hi     = hi_reg;
    assign cfg.margin = margin_reg;

    // doubled slab distances, direction and divider operands
    sbc_slab u_slab (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_word   (seg),
        .out_valid (slab_valid),
        .out_ready (slab_ready),
        .out_word  (slab_word)
    );

    // six quotients, saturated to +-2, 30 fraction bits
    sbc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slab_valid),
        .in_ready  (slab_ready),
        .in_word   (slab_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    // entry max, exit min, hit decision
    sbc_select u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_word   (div_word),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_word  (sel_word)
    );

    // endpoint moves and output register
    sbc_move u_move (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_word   (sel_word),
        .out_valid (clip_valid),
        .out_ready (clip_ready),
        .out_word  (clip)
    );

    // the pipe only refuses input when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !seg_ready |-> (clip_valid && !clip_ready))
        else $error("input refused while pipeline can move");

    // margin write lands in the register
    a_margin_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_MARGIN) |=> (margin_reg == $past(pwdata[MW-1:0])))
        else $error("margin write lost");

    // min x write lands in the register
    a_min_x_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_MIN_X) |=> (lo_reg[0] == $past(pwdata[CW-1:0])))
        else $error("min x write lost");

endmodule

>>> design/sbc_slab.sv
module sbc_slab (
    input  logic              clk,
    input  logic              rst_n,
    input  sbc_pkg::box_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbc_pkg::seg_in_t  in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output sbc_pkg::div_word_t out_word
);
    import sbc_pkg::*;

    logic      vld_reg;
    div_word_t word_reg;
    div_word_t word_next;
    logic [2:0][CW-1:0] s_in;
    logic [2:0][CW-1:0] e_in;
    logic signed [XW-1:0] lo [3];
    logic signed [XW-1:0] hi [3];
    logic signed [XW-1:0] sv [3];
    logic signed [XW-1:0] d [3];
    logic signed [XW-1:0] ext2 [3];
    logic signed [XW-1:0] toc2 [3];
    logic signed [XW-1:0] sx [3];
    logic signed [XW-1:0] den [3];
    logic signed [XW-1:0] num [NL];
    logic signed [XW-1:0] dabs [3];

    assign s_in = {in_word.seg_start_z, in_word.seg_start_y, in_word.seg_start_x};
    assign e_in = {in_word.seg_end_z, in_word.seg_end_y, in_word.seg_end_x};

    always_comb
    begin
        word_next = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            lo[ax]   = XW'($signed(cfg.lo[ax]));
            hi[ax]   = XW'($signed(cfg.hi[ax]));
            sv[ax]   = XW'($signed(s_in[ax]));
            d[ax]    = XW'($signed(e_in[ax])) - sv[ax];
            ext2[ax] = hi[ax] - lo[ax] - $signed(XW'({cfg.margin, 1'b0}));
            toc2[ax] = lo[ax] + hi[ax] - (sv[ax] <<< 1);
            sx[ax]   = (d[ax] > 0) ? ext2[ax] : -ext2[ax];
            den[ax]  = d[ax] <<< 1;
            num[2*ax]   = toc2[ax] - sx[ax];
            num[2*ax+1] = toc2[ax] + sx[ax];
            dabs[ax] = d[ax][XW-1] ? -d[ax] : d[ax];
            word_next.side.s[ax]    = s_in[ax];
            word_next.side.e[ax]    = e_in[ax];
            word_next.side.dz[ax]   = (d[ax] == 0);
            word_next.side.dneg[ax] = d[ax][XW-1];
            word_next.side.dmag[ax] = dabs[ax][CW:0];
            if (d[ax] == 0 && ((num[2*ax] > 0) == (num[2*ax+1] > 0)))
            begin
                word_next.side.zrej = 1'b1;
            end
        end
        for (int l = 0; l < NL; l++)
        begin
            word_next.lane[l].neg = num[l][XW-1] ^ den[l/2][XW-1];
            word_next.lane[l].r   = num[l][XW-1] ? XW'(-num[l]) : XW'(num[l]);
            word_next.lane[l].d   = den[l/2][XW-1] ? XW'(-den[l/2]) : XW'(den[l/2]);
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_word  = word_reg;

endmodule

>>> design/sbc_divider.sv
module sbc_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sbc_pkg::div_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output sbc_pkg::div_word_t out_word
);
    import sbc_pkg::*;

    logic      v   [NST+1];
    logic      rdy [NST+1];
    div_word_t w   [NST+1];

    assign v[0]     = in_valid;
    assign w[0]     = in_word;
    assign in_ready = rdy[0];
    assign rdy[NST] = out_ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic      vld_reg;
        div_word_t word_reg;
        div_word_t word_next;

        always_comb
        begin
            word_next = w[k];
            for (int l = 0; l < NL; l++)
            begin
                word_next.lane[l] = (k == 0) ? div_first(w[k].lane[l])
                                             : div_next(w[k].lane[l]);
            end
        end

        assign rdy[k] = !vld_reg || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg <= v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v[k])
            begin
                word_reg <= word_next;
            end
        end

        assign v[k+1] = vld_reg;
        assign w[k+1] = word_reg;
    end

    assign out_valid = v[NST];
    assign out_word  = w[NST];

endmodule

>>> design/sbc_select.sv
module sbc_select (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sbc_pkg::div_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output sbc_pkg::sel_t      out_word
);
    import sbc_pkg::*;

    logic  vld_reg;
    sel_t  word_reg;
    sel_t  word_next;
    logic signed [TW-1:0] t_near;
    logic signed [TW-1:0] t_far;
    logic signed [TW-1:0] t_one;
    logic signed [TW-1:0] tn [3];
    logic signed [TW-1:0] tf [3];
    logic signed [TW-1:0] tfc;

    assign t_one = $signed(TW'(1) << TF);

    // running max of entry, min of exit over constraining axes
    always_comb
    begin
        t_near = '0;
        t_far  = t_one;
        for (int ax = 0; ax < 3; ax++)
        begin
            tn[ax] = lane_t_value(in_word.lane[2*ax]);
            tf[ax] = lane_t_value(in_word.lane[2*ax+1]);
            if (!in_word.side.dz[ax])
            begin
                if (tn[ax] > t_near)
                begin
                    t_near = tn[ax];
                end
                if (tf[ax] < t_far)
                begin
                    t_far = tf[ax];
                end
            end
        end
        tfc = t_one - t_far;
        word_next.hit  = !in_word.side.zrej && (t_far > t_near);
        word_next.tn   = t_near[TF:0];
        word_next.tfc  = tfc[TF:0];
        word_next.side = in_word.side;
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_word  = word_reg;

endmodule

>>> design/sbc_move.sv
module sbc_move (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbc_pkg::sel_t     in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output sbc_pkg::seg_out_t out_word
);
    import sbc_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [2:0][PW-1:0] ps;
        logic [2:0][PW-1:0] pe;
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] e;
        logic [2:0]         dneg;
    } mul_t;

    logic     mul_vld_reg;
    mul_t     mul_reg;
    mul_t     mul_next;
    logic     mul_ready;
    logic     out_vld_reg;
    seg_out_t out_reg;
    seg_out_t out_next;
    logic [2:0][CW-1:0] ns;
    logic [2:0][CW-1:0] ne;
    logic signed [XW-1:0] ms [3];
    logic signed [XW-1:0] me [3];
    logic signed [XW-1:0] xs [3];
    logic signed [XW-1:0] xe [3];

    // products of |dir| and the two parameters
    always_comb
    begin
        mul_next.hit  = in_word.hit;
        mul_next.s    = in_word.side.s;
        mul_next.e    = in_word.side.e;
        mul_next.dneg = in_word.side.dneg;
        for (int ax = 0; ax < 3; ax++)
        begin
            mul_next.ps[ax] = PW'(in_word.side.dmag[ax]) * PW'(in_word.tn);
            mul_next.pe[ax] = PW'(in_word.side.dmag[ax]) * PW'(in_word.tfc);
        end
    end

    // truncate toward zero, then step each end inward
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            ms[ax] = $signed(XW'(mul_reg.ps[ax] >> TF));
            me[ax] = $signed(XW'(mul_reg.pe[ax] >> TF));
            xs[ax] = XW'($signed(mul_reg.s[ax]));
            xe[ax] = XW'($signed(mul_reg.e[ax]));
            xs[ax] = mul_reg.dneg[ax] ? xs[ax] - ms[ax] : xs[ax] + ms[ax];
            xe[ax] = mul_reg.dneg[ax] ? xe[ax] + me[ax] : xe[ax] - me[ax];
            ns[ax] = mul_reg.hit ? xs[ax][CW-1:0] : mul_reg.s[ax];
            ne[ax] = mul_reg.hit ? xe[ax][CW-1:0] : mul_reg.e[ax];
        end
        out_next.hit          = mul_reg.hit;
        out_next.clip_start_x = ns[0];
        out_next.clip_start_y = ns[1];
        out_next.clip_start_z = ns[2];
        out_next.clip_end_x   = ne[0];
        out_next.clip_end_y   = ne[1];
        out_next.clip_end_z   = ne[2];
    end

    assign mul_ready = !out_vld_reg || out_ready;
    assign in_ready  = !mul_vld_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mul_vld_reg <= in_valid;
            end
            if (mul_ready)
            begin
                out_vld_reg <= mul_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mul_reg <= mul_next;
        end
        if (mul_ready && mul_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_word  = out_reg;

endmodule
